FILE: hw/rtl/dehp_pkg.sv
// Shared types and constants for the DICOM element header parser.
// No dependencies; every other file of the block imports this package.
package dehp_pkg;

  localparam logic [7:0] PREAMBLE_BYTES = 8'd128;

  localparam logic [2:0] KIND_ELEMENT   = 3'd0;
  localparam logic [2:0] KIND_END_OK    = 3'd1;
  localparam logic [2:0] KIND_NOT_DICOM = 3'd2;
  localparam logic [2:0] KIND_TRUNCATED = 3'd3;
  localparam logic [2:0] KIND_UNDEF_LEN = 3'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [15:0] group_number;
    logic [15:0] element_number;
    logic [15:0] value_rep;
    logic [31:0] value_length;
    logic [31:0] value_offset;
    logic        implicit_mode;
    logic [15:0] element_index;
  } out_item_t;

  // Results of one byte: a record, optionally followed by a closing record
  // that shares its offset and mode.
  typedef struct packed {
    out_item_t   rec;
    logic        second;
    logic [2:0]  second_kind;
    logic [15:0] second_index;
  } dehp_entry_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = "D";
      2'd1:    m = "I";
      2'd2:    m = "C";
      default: m = "M";
    endcase
    return m;
  endfunction

  function automatic logic is_long_rep(input logic [15:0] vr);
    logic r;
    case (vr)
      "OB", "OF", "OW", "SQ", "UN", "UT": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_short_rep(input logic [15:0] vr);
    logic r;
    case (vr)
      "AE", "AS", "AT", "CS", "DA", "DS", "DT", "FD", "FL", "IS", "LO",
      "LT", "PN", "SH", "SL", "SS", "ST", "TM", "UI", "UL", "US": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/dicom_element_header_parser_top.sv
// Top level of the DICOM element header parser: front parser, entry queue
// and output stage. Depends on dehp_pkg, dehp_front, dehp_fifo and dehp_back.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------------------
//   input    | in_push / in_full | in_item  (in_item_t)
//   result   | out_pop / out_empty | out_item (out_item_t)
//
// One byte is taken per cycle while in_full is low; each byte is parsed in the
// cycle it is taken. A result passes the entry queue and then the output
// register; a byte giving two records presents them one after the other.
// The four-entry queue decouples parsing from the consumer; in_full rises only
// when it is full. Reset is synchronous and active low.
module dicom_element_header_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  dehp_pkg::in_item_t  in_item,
  input  logic                out_pop,
  output logic                out_empty,
  output dehp_pkg::out_item_t out_item
);
  import dehp_pkg::*;

  logic        accept;
  logic        f_push;
  dehp_entry_t f_entry;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  dehp_entry_t q_data;

  assign in_full = q_full;
  assign accept  = in_push & ~q_full;

  dehp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .push   (f_push),
    .entry  (f_entry)
  );

  dehp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_data (f_entry),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  dehp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .pop     (out_pop),
    .empty   (out_empty),
    .data    (out_item)
  );

endmodule

FILE: hw/rtl/dehp_front.sv
// Front part of the parser: byte-level phase machine that builds records.
// Depends on dehp_pkg; feeds the entry queue (dehp_fifo).
module dehp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  dehp_pkg::in_item_t   item,
  output logic                 push,
  output dehp_pkg::dehp_entry_t entry
);
  import dehp_pkg::*;

  localparam logic [3:0] PH_PRE   = 4'd0;
  localparam logic [3:0] PH_MAGIC = 4'd1;
  localparam logic [3:0] PH_TAG   = 4'd2;
  localparam logic [3:0] PH_VR    = 4'd3;
  localparam logic [3:0] PH_RSV   = 4'd4;
  localparam logic [3:0] PH_LEN16 = 4'd5;
  localparam logic [3:0] PH_LEN32 = 4'd6;
  localparam logic [3:0] PH_SKIP  = 4'd7;
  localparam logic [3:0] PH_DONE  = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] group_r, group_nxt;
  logic [15:0] elem_r, elem_nxt;
  logic [15:0] rep_r, rep_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] off_r, off_nxt;
  logic        expl_r, expl_nxt;
  logic [15:0] count_r, count_nxt;

  logic [7:0]  b;
  logic [3:0]  ph;
  logic [7:0]  c;
  logic [7:0]  c_inc;
  logic [15:0] rep_full;
  logic [31:0] len_new;
  logic        hdr_done;
  logic        rec_valid;
  out_item_t   hdr_rec;
  out_item_t   close_rec;
  logic        close_valid;
  logic [2:0]  close_kind;

  always_comb begin
    b           = item.data_byte;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    group_nxt   = group_r;
    elem_nxt    = elem_r;
    rep_nxt     = rep_r;
    len_nxt     = len_r;
    skip_nxt    = skip_r;
    off_nxt     = off_r;
    expl_nxt    = expl_r;
    count_nxt   = count_r;
    hdr_done    = 1'b0;
    rec_valid   = 1'b0;
    close_valid = 1'b0;
    close_kind  = KIND_END_OK;
    rep_full    = {rep_r[15:8], b};
    len_new     = len_r;
    hdr_rec     = '0;
    ph          = phase_r;
    c           = cnt_r;
    c_inc       = cnt_r + 8'd1;

    if (accept && phase_r != PH_DONE) begin
      off_nxt = off_r + 32'd1;
      // An empty preamble moves straight on to the magic bytes.
      if (ph == PH_PRE && c >= PREAMBLE_BYTES) begin
        ph = PH_MAGIC;
        c  = 8'd0;
      end
      c_inc     = c + 8'd1;
      phase_nxt = ph;
      cnt_nxt   = c;

      case (ph)
        PH_PRE: begin
          cnt_nxt = c_inc;
          if (c_inc >= PREAMBLE_BYTES) begin
            phase_nxt = PH_MAGIC;
            cnt_nxt   = 8'd0;
          end
        end
        PH_MAGIC: begin
          if (b != magic_byte(c[1:0])) begin
            close_valid = 1'b1;
            close_kind  = KIND_NOT_DICOM;
            phase_nxt   = PH_DONE;
          end else begin
            cnt_nxt = c_inc;
            if (c_inc >= 8'd4) begin
              phase_nxt = PH_TAG;
              cnt_nxt   = 8'd0;
            end
          end
        end
        PH_TAG: begin
          case (c[1:0])
            2'd0:    group_nxt = {8'd0, b};
            2'd1:    group_nxt = {b, group_r[7:0]};
            2'd2:    elem_nxt  = {8'd0, b};
            default: elem_nxt  = {b, elem_r[7:0]};
          endcase
          cnt_nxt = c_inc;
          if (c_inc >= 8'd4) begin
            cnt_nxt = 8'd0;
            len_nxt = '0;
            if (expl_r) begin
              phase_nxt = PH_VR;
            end else begin
              rep_nxt   = '0;
              phase_nxt = PH_LEN32;
            end
          end
        end
        PH_VR: begin
          if (c == 8'd0) begin
            rep_nxt = {b, 8'd0};
            cnt_nxt = 8'd1;
          end else begin
            rep_nxt = rep_full;
            cnt_nxt = 8'd0;
            if (is_long_rep(rep_full)) begin
              phase_nxt = PH_RSV;
            end else if (is_short_rep(rep_full)) begin
              phase_nxt = PH_LEN16;
            end else begin
              // Unknown representation: its bytes start a 32-bit length.
              len_nxt   = {16'd0, b, rep_r[15:8]};
              expl_nxt  = 1'b0;
              rep_nxt   = '0;
              phase_nxt = PH_LEN32;
              cnt_nxt   = 8'd2;
            end
          end
        end
        PH_RSV: begin
          cnt_nxt = c_inc;
          if (c_inc >= 8'd2) begin
            phase_nxt = PH_LEN32;
            cnt_nxt   = 8'd0;
            len_nxt   = '0;
          end
        end
        PH_LEN16, PH_LEN32: begin
          case (c[1:0])
            2'd0:    len_new = len_r | {24'd0, b};
            2'd1:    len_new = len_r | {16'd0, b, 8'd0};
            2'd2:    len_new = len_r | {8'd0, b, 16'd0};
            default: len_new = len_r | {b, 24'd0};
          endcase
          if (ph == PH_LEN16 && c[0]) begin
            len_new = len_r | {16'd0, b, 8'd0};
          end
          len_nxt  = len_new;
          cnt_nxt  = c_inc;
          hdr_done = (ph == PH_LEN16) ? (c_inc >= 8'd2) : (c_inc >= 8'd4);
        end
        PH_SKIP: begin
          skip_nxt = (skip_r != 32'd0) ? skip_r - 32'd1 : 32'd0;
          if (skip_nxt == 32'd0) begin
            phase_nxt = PH_TAG;
            cnt_nxt   = 8'd0;
          end
        end
        default: begin
        end
      endcase

      if (hdr_done) begin
        rec_valid                = 1'b1;
        hdr_rec.group_number     = group_r;
        hdr_rec.element_number   = elem_r;
        hdr_rec.value_rep        = expl_r ? rep_r : 16'd0;
        hdr_rec.value_length     = len_new;
        hdr_rec.value_offset     = off_nxt;
        hdr_rec.implicit_mode    = ~expl_r;
        hdr_rec.element_index    = count_r;
        if (len_new == 32'hFFFF_FFFF) begin
          hdr_rec.record_kind = KIND_UNDEF_LEN;
          phase_nxt           = PH_DONE;
        end else begin
          hdr_rec.record_kind = KIND_ELEMENT;
          if (count_r != 16'hFFFF) begin
            count_nxt = count_r + 16'd1;
          end
          skip_nxt  = len_new;
          phase_nxt = (len_new != 32'd0) ? PH_SKIP : PH_TAG;
          cnt_nxt   = 8'd0;
        end
      end

      if (item.last_byte && phase_nxt != PH_DONE) begin
        close_valid = 1'b1;
        if (phase_nxt == PH_PRE || phase_nxt == PH_MAGIC) begin
          close_kind = KIND_NOT_DICOM;
        end else if (phase_nxt == PH_TAG && cnt_nxt == 8'd0) begin
          close_kind = KIND_END_OK;
        end else begin
          close_kind = KIND_TRUNCATED;
        end
        phase_nxt = PH_DONE;
      end
    end

    close_rec               = '0;
    close_rec.record_kind   = close_kind;
    close_rec.value_offset  = off_nxt;
    close_rec.implicit_mode = ~expl_nxt;
    close_rec.element_index = count_nxt;

    push               = rec_valid | close_valid;
    entry.rec          = rec_valid ? hdr_rec : close_rec;
    entry.second       = rec_valid & close_valid;
    entry.second_kind  = close_kind;
    entry.second_index = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE;
      cnt_r   <= '0;
      group_r <= '0;
      elem_r  <= '0;
      rep_r   <= '0;
      len_r   <= '0;
      skip_r  <= '0;
      off_r   <= '0;
      expl_r  <= 1'b1;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      group_r <= group_nxt;
      elem_r  <= elem_nxt;
      rep_r   <= rep_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
      off_r   <= off_nxt;
      expl_r  <= expl_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/dehp_fifo.sv
// Short queue of per-byte result entries between front and back parts.
// Depends on dehp_pkg for the entry type and depth.
module dehp_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  dehp_pkg::dehp_entry_t wr_data,
  input  logic                  rd_en,
  output dehp_pkg::dehp_entry_t rd_data,
  output logic                  full,
  output logic                  empty
);
  import dehp_pkg::*;

  dehp_entry_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, wp_nxt;
  logic [FIFO_AW-1:0]   rp_r, rp_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + FIFO_AW'(1) : wp_r;
    rp_nxt  = rd_en ? rp_r + FIFO_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW + 1)'(wr_en) - (FIFO_AW + 1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/dehp_back.sv
// Back part: takes queue entries and presents one record at a time in an
// output register, splitting entries that carry a closing record. Uses dehp_pkg.
module dehp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  dehp_pkg::dehp_entry_t q_data,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output dehp_pkg::out_item_t   data
);
  import dehp_pkg::*;

  out_item_t   out_r, out_nxt;
  logic        valid_r, valid_nxt;
  logic        pend_r, pend_nxt;
  logic [2:0]  pend_kind_r, pend_kind_nxt;
  logic [15:0] pend_index_r, pend_index_nxt;
  out_item_t   second_rec;

  assign empty = ~valid_r;
  assign data  = out_r;

  always_comb begin
    // The closing record shares offset and mode with the record before it.
    second_rec               = '0;
    second_rec.record_kind   = pend_kind_r;
    second_rec.value_offset  = out_r.value_offset;
    second_rec.implicit_mode = out_r.implicit_mode;
    second_rec.element_index = pend_index_r;

    out_nxt        = out_r;
    valid_nxt      = valid_r;
    pend_nxt       = pend_r;
    pend_kind_nxt  = pend_kind_r;
    pend_index_nxt = pend_index_r;
    q_pop          = 1'b0;

    if (!valid_r || pop) begin
      if (pend_r) begin
        out_nxt   = second_rec;
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end else if (!q_empty) begin
        out_nxt        = q_data.rec;
        valid_nxt      = 1'b1;
        pend_nxt       = q_data.second;
        pend_kind_nxt  = q_data.second_kind;
        pend_index_nxt = q_data.second_index;
        q_pop          = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r        <= out_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_index_r <= pend_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

FILE: tb/dehp_record_checker.sv
// Record checker for the DICOM element header parser: watches both queue ports,
// predicts the records of every accepted byte and compares them in order.
// Depends on dehp_pkg for the channel payload types and the record kinds.
module dehp_record_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  dehp_pkg::in_item_t  in_item,
  input  logic                out_pop,
  input  logic                out_empty,
  input  dehp_pkg::out_item_t out_item,
  output int                  fail_total,
  output int                  records_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import dehp_pkg::*;

  typedef enum logic [3:0] {
    ST_PREAMBLE, ST_MAGIC, ST_TAG, ST_REP, ST_RESERVED, ST_LEN16, ST_LEN32, ST_SKIP,
    ST_STOPPED
  } parse_state_t;

  localparam logic [31:0] MAGIC_WORD = "DICM";

  parse_state_t pstate;
  logic [7:0]   nbytes;
  logic [15:0]  grp;
  logic [15:0]  elem;
  logic [15:0]  rep;
  logic [31:0]  len_acc;
  logic [31:0]  skip_left;
  logic [31:0]  offset;
  logic         explicit_vr;
  logic [15:0]  elem_count;
  out_item_t    records_due[$];
  int           seen;

  initial begin
    fail_total = 0;
    records_waiting = 0;
    seen = 0;
  end

  function automatic bit rep_has_long_length(input logic [15:0] vr);
    case (vr)
      "OB", "OF", "OW", "SQ", "UN", "UT": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit rep_has_short_length(input logic [15:0] vr);
    case (vr)
      "AE", "AS", "AT", "CS", "DA", "DS", "DT", "FD", "FL", "IS", "LO",
      "LT", "PN", "SH", "SL", "SS", "ST", "TM", "UI", "UL", "US": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t ns: record %0d: %s expected %0h, got %0h", $time, seen, what, want, got);
    fail_total++;
  endtask

  task automatic add_record(input logic [2:0] kind, input logic [15:0] g, input logic [15:0] e,
                            input logic [15:0] vr, input logic [31:0] len);
    out_item_t r;
    r.record_kind    = kind;
    r.group_number   = g;
    r.element_number = e;
    r.value_rep      = vr;
    r.value_length   = len;
    r.value_offset   = offset;
    r.implicit_mode  = !explicit_vr;
    r.element_index  = elem_count;
    records_due.push_back(r);
  endtask

  task automatic close_header();
    logic [15:0] vr;
    vr = explicit_vr ? rep : 16'h0000;
    if (len_acc == 32'hFFFF_FFFF) begin
      // An undefined length cannot be skipped, so parsing ends here.
      add_record(KIND_UNDEF_LEN, grp, elem, vr, len_acc);
      pstate = ST_STOPPED;
    end else begin
      add_record(KIND_ELEMENT, grp, elem, vr, len_acc);
      if (elem_count != 16'hFFFF) elem_count++;
      skip_left = len_acc;
      pstate = (len_acc != 0) ? ST_SKIP : ST_TAG;
      nbytes = 8'd0;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic fin);
    logic [2:0] kind;
    if (pstate == ST_STOPPED) return;
    offset++;
    if (pstate == ST_PREAMBLE && nbytes >= PREAMBLE_BYTES) begin
      pstate = ST_MAGIC;
      nbytes = 8'd0;
    end
    case (pstate)
      ST_PREAMBLE: begin
        nbytes++;
        if (nbytes >= PREAMBLE_BYTES) begin
          pstate = ST_MAGIC;
          nbytes = 8'd0;
        end
      end
      ST_MAGIC: begin
        if (b != MAGIC_WORD[8 * (3 - nbytes[1:0]) +: 8]) begin
          add_record(KIND_NOT_DICOM, 16'h0, 16'h0, 16'h0, 32'h0);
          pstate = ST_STOPPED;
          return;
        end
        nbytes++;
        if (nbytes >= 4) begin
          pstate = ST_TAG;
          nbytes = 8'd0;
        end
      end
      ST_TAG: begin
        case (nbytes[1:0])
          2'd0:    grp = {8'h00, b};
          2'd1:    grp[15:8] = b;
          2'd2:    elem = {8'h00, b};
          default: elem[15:8] = b;
        endcase
        nbytes++;
        if (nbytes >= 4) begin
          nbytes = 8'd0;
          len_acc = 32'h0;
          if (explicit_vr) begin
            pstate = ST_REP;
          end else begin
            rep = 16'h0000;
            pstate = ST_LEN32;
          end
        end
      end
      ST_REP: begin
        if (nbytes == 0) begin
          rep = {b, 8'h00};
          nbytes = 8'd1;
        end else begin
          rep[7:0] = b;
          nbytes = 8'd0;
          if (rep_has_long_length(rep)) begin
            pstate = ST_RESERVED;
          end else if (rep_has_short_length(rep)) begin
            pstate = ST_LEN16;
          end else begin
            // An unknown representation is really the low half of an implicit length.
            len_acc = {16'h0000, rep[7:0], rep[15:8]};
            explicit_vr = 1'b0;
            rep = 16'h0000;
            pstate = ST_LEN32;
            nbytes = 8'd2;
          end
        end
      end
      ST_RESERVED: begin
        nbytes++;
        if (nbytes >= 2) begin
          pstate = ST_LEN32;
          nbytes = 8'd0;
          len_acc = 32'h0;
        end
      end
      ST_LEN16: begin
        len_acc |= {24'h0, b} << (8 * nbytes[0]);
        nbytes++;
        if (nbytes >= 2) close_header();
      end
      ST_LEN32: begin
        len_acc |= {24'h0, b} << (8 * nbytes[1:0]);
        nbytes++;
        if (nbytes >= 4) close_header();
      end
      default: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          pstate = ST_TAG;
          nbytes = 8'd0;
        end
      end
    endcase

    if (fin && pstate != ST_STOPPED) begin
      if (pstate == ST_PREAMBLE || pstate == ST_MAGIC) kind = KIND_NOT_DICOM;
      else if (pstate == ST_TAG && nbytes == 0) kind = KIND_END_OK;
      else kind = KIND_TRUNCATED;
      add_record(kind, 16'h0, 16'h0, 16'h0, 32'h0);
      pstate = ST_STOPPED;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (records_due.size() == 0) begin
      report("record with none pending, kind", 32'h0, 32'(got.record_kind));
    end else begin
      want = records_due.pop_front();
      if (got.record_kind !== want.record_kind)
        report("record_kind", 32'(want.record_kind), 32'(got.record_kind));
      if (got.group_number !== want.group_number)
        report("group_number", 32'(want.group_number), 32'(got.group_number));
      if (got.element_number !== want.element_number)
        report("element_number", 32'(want.element_number), 32'(got.element_number));
      if (got.value_rep !== want.value_rep)
        report("value_rep", 32'(want.value_rep), 32'(got.value_rep));
      if (got.value_length !== want.value_length)
        report("value_length", want.value_length, got.value_length);
      if (got.value_offset !== want.value_offset)
        report("value_offset", want.value_offset, got.value_offset);
      if (got.implicit_mode !== want.implicit_mode)
        report("implicit_mode", 32'(want.implicit_mode), 32'(got.implicit_mode));
      if (got.element_index !== want.element_index)
        report("element_index", 32'(want.element_index), 32'(got.element_index));
    end
    seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pstate = ST_PREAMBLE;
      nbytes = 8'd0;
      grp = 16'h0;
      elem = 16'h0;
      rep = 16'h0;
      len_acc = 32'h0;
      skip_left = 32'h0;
      offset = 32'h0;
      explicit_vr = 1'b1;
      elem_count = 16'h0;
      records_due.delete();
    end else begin
      if (in_push && !in_full) take_byte(in_item.data_byte, in_item.last_byte);
      if (out_pop && !out_empty) check_result(out_item);
    end
    records_waiting = records_due.size();
  end

endmodule

FILE: tb/dicom_element_header_parser_top_test.sv
// Top of the parser testbench: builds one DICOM byte stream, feeds it with random
// gaps and stalls, and gives the verdict. Depends on dehp_pkg, the parser top
// level and dehp_record_checker.
module dicom_element_header_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dehp_pkg::*;

  typedef enum int {FORM_LONG, FORM_SHORT, FORM_ODD} elem_form_t;

  localparam int FULL_HEADER = 100;
  localparam logic [15:0] LONG_VRS [6] = '{"OB", "OF", "OW", "SQ", "UN", "UT"};
  localparam logic [15:0] SHORT_VRS [21] = '{
    "AE", "AS", "AT", "CS", "DA", "DS", "DT", "FD", "FL", "IS", "LO",
    "LT", "PN", "SH", "SL", "SS", "ST", "TM", "UI", "UL", "US"
  };

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_pop;
  logic      out_empty;
  out_item_t out_item;
  int        fail_total;
  int        records_waiting;
  int        tx_idle;
  int        rx_idle;
  bit        hold_req;
  bit        implicit_gen;
  in_item_t  byte_stream[$];

  dicom_element_header_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  dehp_record_checker record_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_item         (in_item),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_item        (out_item),
    .fail_total      (fail_total),
    .records_waiting (records_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = 1'b0;
    byte_stream.push_back(it);
  endtask

  // Appends one element: hdr_keep header bytes at most, then val_keep value bytes
  // if the header went out whole. pick selects a representation, or -1 for random.
  task automatic add_element(input logic [15:0] g, input logic [15:0] e,
                             input elem_form_t form, input int pick, input logic [31:0] len,
                             input int hdr_keep, input int val_keep);
    logic [7:0]  hdr[$];
    logic [15:0] vr;
    hdr.push_back(g[7:0]);
    hdr.push_back(g[15:8]);
    hdr.push_back(e[7:0]);
    hdr.push_back(e[15:8]);
    if (implicit_gen || form == FORM_ODD) begin
      // An odd element carries a length below 256, so its second byte is zero
      // and the pair can never read as a known representation.
      for (int k = 0; k < 4; k++) hdr.push_back(len[8 * k +: 8]);
      implicit_gen = 1'b1;
    end else if (form == FORM_LONG) begin
      vr = LONG_VRS[(pick < 0) ? $urandom_range(5) : pick];
      hdr.push_back(vr[15:8]);
      hdr.push_back(vr[7:0]);
      hdr.push_back(8'($urandom));
      hdr.push_back(8'($urandom));
      for (int k = 0; k < 4; k++) hdr.push_back(len[8 * k +: 8]);
    end else begin
      vr = SHORT_VRS[(pick < 0) ? $urandom_range(20) : pick];
      hdr.push_back(vr[15:8]);
      hdr.push_back(vr[7:0]);
      hdr.push_back(len[7:0]);
      hdr.push_back(len[15:8]);
    end
    for (int i = 0; i < hdr.size() && i < hdr_keep; i++) put_byte(hdr[i]);
    if (hdr_keep >= hdr.size()) begin
      for (int i = 0; i < val_keep; i++) put_byte(8'($urandom));
    end
  endtask

  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 32'd0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 98) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic build_stream();
    logic [31:0] len;
    int          ending;
    bit          close_here;
    implicit_gen = 1'b0;
    for (int i = 0; i < PREAMBLE_BYTES; i++) put_byte(8'($urandom));
    put_byte("D");
    put_byte("I");
    put_byte("C");
    put_byte("M");

    // Tag extremes, then every long representation with a small length.
    add_element(16'h0000, 16'h0000, FORM_SHORT, 0, 32'd0, FULL_HEADER, 0);
    add_element(16'hFFFF, 16'hFFFF, FORM_SHORT, 20, 32'd2, FULL_HEADER, 2);
    for (int i = 0; i < 6; i++) begin
      add_element(16'($urandom), 16'($urandom), FORM_LONG, i, i, FULL_HEADER, i);
    end

    while (byte_stream.size() < 320) begin
      len = pick_length();
      add_element(16'($urandom), 16'($urandom), $urandom_range(1) ? FORM_LONG : FORM_SHORT,
                  -1, len, FULL_HEADER, len);
    end
    // Drop into implicit mode for the rest of the file.
    len = $urandom_range(0, 40);
    add_element(16'($urandom), 16'($urandom), FORM_ODD, -1, len, FULL_HEADER, len);
    while (byte_stream.size() < 570) begin
      len = pick_length();
      add_element(16'($urandom), 16'($urandom), FORM_LONG, -1, len, FULL_HEADER, len);
    end

    ending = $urandom_range(4);
    close_here = 1'b1;
    case (ending)
      0: begin
        len = pick_length();
        add_element(16'($urandom), 16'($urandom), FORM_LONG, -1, len, FULL_HEADER, len);
      end
      1: begin
        len = $urandom_range(2, 20);
        add_element(16'($urandom), 16'($urandom), FORM_LONG, -1, len, FULL_HEADER,
                    $urandom_range(1, len - 1));
      end
      2: begin
        add_element(16'($urandom), 16'($urandom), FORM_LONG, -1, 32'd4,
                    $urandom_range(1, 7), 0);
      end
      3: begin
        add_element(16'($urandom), 16'($urandom), FORM_LONG, -1, 32'hFFFF_FFFF,
                    FULL_HEADER, 0);
        close_here = 1'b0;
      end
      default: begin
        len = $urandom_range(1, 20);
        add_element(16'($urandom), 16'($urandom), FORM_LONG, -1, len, FULL_HEADER, 0);
      end
    endcase
    if (close_here) byte_stream[byte_stream.size() - 1].last_byte = 1'b1;

    // Parsing has stopped by now, so these bytes must leave no trace.
    for (int i = 0; i < 10; i++) begin
      put_byte(8'($urandom));
      byte_stream[byte_stream.size() - 1].last_byte = 1'($urandom_range(1));
    end
  endtask

  // Result side: random pops, with one long hold-off when asked for.
  initial begin
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (150) @(negedge clk);
        hold_req = 1'b0;
      end
      out_pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    int third;
    int pause_at;
    int hold_at;
    int drain;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 1'b0;
    build_stream();
    third = byte_stream.size() / 3;
    pause_at = byte_stream.size() / 2;
    hold_at = (3 * byte_stream.size()) / 4;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i < third) begin
        tx_idle = 24;
        rx_idle = 75;
      end else if (i < 2 * third) begin
        tx_idle = 75;
        rx_idle = 24;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (i == pause_at) begin
        // Hold back the next request until every pending record is out.
        in_push <= 1'b0;
        @(negedge clk);
        while (records_waiting != 0) @(negedge clk);
      end
      if (i == hold_at) hold_req = 1'b1;
      while ($urandom_range(99) < tx_idle) begin
        in_push <= 1'b0;
        @(negedge clk);
      end
      in_push <= 1'b1;
      in_item <= byte_stream[i];
      // in_full only moves at the rising edge, so its value here decides the
      // coming edge.
      while (in_full) @(negedge clk);
      @(negedge clk);
    end
    in_push <= 1'b0;

    drain = 0;
    while (records_waiting != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    if (records_waiting != 0) begin
      $display("Some tests failed");
      $finish;
    end else begin
      repeat (20) @(negedge clk);
      if (fail_total == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
      $finish;
    end
  end

endmodule

FILE: filelist.f
hw/rtl/dehp_pkg.sv
hw/rtl/dehp_front.sv
hw/rtl/dehp_fifo.sv
hw/rtl/dehp_back.sv
hw/rtl/dicom_element_header_parser_top.sv
tb/dehp_record_checker.sv
tb/dicom_element_header_parser_top_test.sv
